// File: src/skts_pkg.sv
package skts_pkg;

  // Field widths of the item and result words
  localparam int KEY_W   = 24;
  localparam int VAL_W   = 24;
  localparam int IN_IDX_W = 10;
  localparam int CNT_W   = 11;

  // Input word layout: entry_index, key, entry_value from bit 0 up, padded to 64 bits
  localparam int S_IDX_LSB  = 0;
  localparam int S_KEY_LSB  = S_IDX_LSB + IN_IDX_W;
  localparam int S_VAL_LSB  = S_KEY_LSB + KEY_W;
  localparam int S_DATA_W   = 64;
  localparam int M_DATA_W   = 24;

  // Item kinds carried in the input tuser bit
  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_t;

  // Search sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_RESULT
  } state_t;

  // One input word as seen by the search core
  typedef struct packed {
    func_t                func;
    logic [IN_IDX_W-1:0]  entry_index;
    logic [KEY_W-1:0]     key;
    logic [VAL_W-1:0]     entry_value;
  } item_t;

  // One lookup result
  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] found_offset;
  } result_t;

endpackage

// File: src/sorted_key_table_search_top.sv
// Sorted key table with binary search. Each input word either writes one
// key/value entry (tuser 0) or looks up a key (tuser 1) over the first
// entry_count entries, which are expected to be sorted by key in ascending
// order. A write gives no result. A lookup makes at most
// clog2(TABLE_DEPTH)+1 probes of the key/value memory (11 at the default
// depth), or none when the clamped count is zero; the next word is taken in
// the cycle the result moves into the output register, which holds it while
// the master side stalls.
// Entries come out of reset undefined: a lookup must only probe entries that
// were written. entry_count above TABLE_DEPTH searches the whole table;
// writes at an index at or beyond TABLE_DEPTH are dropped. Write entry_count
// only while no lookup is in flight.
module sorted_key_table_search_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration: entry_count
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [skts_pkg::CNT_W-1:0]    cfg_data,
  // Input words
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // entry_index [9:0], key [33:10], entry_value [57:34], zero [63:58]
  input  logic [skts_pkg::S_DATA_W-1:0] s_axis_tdata,
  // func [0]
  input  logic                          s_axis_tuser,
  // Result words
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // found_offset [23:0]
  output logic [skts_pkg::M_DATA_W-1:0] m_axis_tdata,
  // found [0]
  output logic                          m_axis_tuser
);
  import skts_pkg::*;

  logic [CNT_W-1:0] entry_count;
  item_t            item;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  logic             out_valid;
  result_t          out_res;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_valid) begin
      entry_count <= cfg_data;
    end
  end

  // Unpack the input word
  assign item.func        = func_t'(s_axis_tuser);
  assign item.entry_index = s_axis_tdata[S_IDX_LSB +: IN_IDX_W];
  assign item.key         = s_axis_tdata[S_KEY_LSB +: KEY_W];
  assign item.entry_value = s_axis_tdata[S_VAL_LSB +: VAL_W];

  skts_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .entry_count (entry_count),
    .item_valid  (s_axis_tvalid),
    .item_ready  (s_axis_tready),
    .item        (item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // Output register: load when empty or drained this cycle
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res.found_offset;
  assign m_axis_tuser  = out_res.found;

endmodule

// File: src/skts_core.sv
module skts_core #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [skts_pkg::CNT_W-1:0] entry_count,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  skts_pkg::item_t        item,
  output logic                   res_valid,
  input  logic                   res_ready,
  output skts_pkg::result_t      res
);
  import skts_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int BW = IW + 1;
  localparam int SW = (BW > CNT_W) ? BW : CNT_W;
  localparam int MW = KEY_W + VAL_W;

  state_t state, state_next;

  // Search bounds, current probe and the key under search
  logic [BW-1:0]    low, low_next;
  logic [BW-1:0]    high, high_next;
  logic [IW-1:0]    mid, mid_next;
  logic [KEY_W-1:0] key_q, key_q_next;
  logic             res_found, res_found_next;
  logic [VAL_W-1:0] res_value, res_value_next;

  // Key/value memory, value in the upper half
  logic [MW-1:0]    mem [TABLE_DEPTH];
  logic [MW-1:0]    rd_q;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic             wr_en;

  logic             start;
  logic [BW-1:0]    high0;
  logic [IW-1:0]    mid0;
  logic [SW-1:0]    cnt_ext;
  logic             wr_in_range;
  logic [KEY_W-1:0] probe_key;
  logic [VAL_W-1:0] probe_val;
  logic             eq, lt;
  logic [BW-1:0]    mid_ext, lo_up;
  logic [BW:0]      sum_up, sum_dn;
  logic [IW-1:0]    mid_up, mid_dn;
  logic             more_up, more_dn;

  // Handshake toward the input and result sides
  assign item_ready = (state == S_IDLE) || ((state == S_RESULT) && res_ready);
  assign res_valid  = (state == S_RESULT);
  assign res.found        = res_found;
  assign res.found_offset = res_value;
  assign start      = item_valid && item_ready;

  // Clamp the count to the table depth for the initial upper bound
  assign cnt_ext = SW'(entry_count);
  assign high0   = (cnt_ext > SW'(TABLE_DEPTH)) ? BW'(TABLE_DEPTH) : BW'(cnt_ext);
  assign mid0    = IW'(high0 >> 1);
  assign wr_in_range = (32'(item.entry_index) < 32'(TABLE_DEPTH));

  // Compare the probed key, precompute both possible next probes
  assign probe_key = rd_q[KEY_W-1:0];
  assign probe_val = rd_q[MW-1:KEY_W];
  assign eq        = (probe_key == key_q);
  assign lt        = (probe_key < key_q);
  assign mid_ext   = BW'(mid);
  assign lo_up     = mid_ext + BW'(1);
  assign sum_up    = (BW+1)'(lo_up) + (BW+1)'(high);
  assign sum_dn    = (BW+1)'(low) + (BW+1)'(mid_ext);
  assign mid_up    = IW'(sum_up >> 1);
  assign mid_dn    = IW'(sum_dn >> 1);
  assign more_up   = (lo_up < high);
  assign more_dn   = (low < mid_ext);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE, S_RESULT: begin
        if (start) begin
          if (item.func == FUNC_LOOKUP) begin
            state_next = (high0 == '0) ? S_RESULT : S_PROBE;
          end else begin
            state_next = S_IDLE;
          end
        end else if (state == S_RESULT && res_ready) begin
          state_next = S_IDLE;
        end
      end
      S_PROBE: begin
        if (eq) begin
          state_next = S_RESULT;
        end else if (lt) begin
          state_next = more_up ? S_PROBE : S_RESULT;
        end else begin
          state_next = more_dn ? S_PROBE : S_RESULT;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Bounds, memory access and result values
  always_comb begin
    low_next       = low;
    high_next      = high;
    mid_next       = mid;
    key_q_next     = key_q;
    res_found_next = res_found;
    res_value_next = res_value;
    rd_en          = 1'b0;
    rd_addr        = mid0;
    wr_en          = 1'b0;
    unique case (state)
      S_IDLE, S_RESULT: begin
        if (start && item.func == FUNC_LOOKUP) begin
          key_q_next = item.key;
          low_next   = '0;
          high_next  = high0;
          mid_next   = mid0;
          rd_en      = (high0 != '0);
          rd_addr    = mid0;
          if (high0 == '0) begin
            res_found_next = 1'b0;
            res_value_next = '0;
          end
        end else if (start) begin
          wr_en = wr_in_range;
        end
      end
      S_PROBE: begin
        if (eq) begin
          res_found_next = 1'b1;
          res_value_next = probe_val;
        end else if (lt) begin
          low_next = lo_up;
          mid_next = mid_up;
          rd_addr  = mid_up;
          rd_en    = more_up;
          if (!more_up) begin
            res_found_next = 1'b0;
            res_value_next = '0;
          end
        end else begin
          high_next = mid_ext;
          mid_next  = mid_dn;
          rd_addr   = mid_dn;
          rd_en     = more_dn;
          if (!more_dn) begin
            res_found_next = 1'b0;
            res_value_next = '0;
          end
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    low       <= low_next;
    high      <= high_next;
    mid       <= mid_next;
    key_q     <= key_q_next;
    res_found <= res_found_next;
    res_value <= res_value_next;
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IW'(item.entry_index)] <= {item.entry_value, item.key};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // A probe always lies inside a non-empty window
  a_probe_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (low < high) && (BW'(mid) >= low) && (BW'(mid) < high))
    else $error("probe outside search window");

  // The window never reaches past the table
  a_high_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (high <= BW'(TABLE_DEPTH)))
    else $error("search bound beyond table depth");

  // No table write during a search
  a_no_write_in_search: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state != S_PROBE))
    else $error("table written while searching");

  // Each continued probe issues a memory read
  a_probe_reads: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE && state_next == S_PROBE) |-> rd_en)
    else $error("probe continues without a read");

  // A miss never carries a value
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT && !res_found) |-> (res_value == '0))
    else $error("miss with nonzero value");

endmodule
